### hw/rtl/fhsd_pkg.sv
package fhsd_pkg;

   // Hash constants.
   localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
   localparam logic [31:0] FNV_PRIME = 32'h0100_0193;
   localparam logic [31:0] NULL_WORD = 32'hF0F0_F0F1;

   // Segment reduction sizing.
   localparam int MAX_SEGMENTS = 4096;
   localparam int SEG_W        = $clog2(MAX_SEGMENTS);
   localparam int REM_W        = SEG_W + 1;
   localparam int CNT_W        = 13;

   // Hash queue between the front and the back. The depth is a power of two.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Division step counter.
   localparam int DIV_STEPS = 32;
   localparam int DIV_CW    = $clog2(DIV_STEPS);

   // Item kinds.
   typedef enum logic [1:0] {
      ACT_KEY   = 2'd0,
      ACT_NULL  = 2'd1,
      ACT_NOKEY = 2'd2
   } action_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_SEGMENT_COUNT     = 2'd0,
      CSR_HASH_VARIANT      = 2'd1,
      CSR_ROUND_ROBIN_START = 2'd2
   } csr_index_type;

   // Write side of the hash queue.
   typedef struct packed {
      logic        push;
      logic [31:0] hash;
   } q_wr_type;

   // Read side of the hash queue.
   typedef struct packed {
      logic        valid;
      logic [31:0] hash;
   } q_rd_type;

   // Load of the round-robin counter from the configuration port.
   typedef struct packed {
      logic        load;
      logic [31:0] value;
   } rr_load_type;

   // One FNV step: variant 0 multiplies then xors, variant 1 xors then multiplies.
   function automatic logic [31:0] fnv_mix(input logic [31:0] h, input logic [7:0] b,
                                           input logic variant);
      logic [31:0] x;
      if (variant) begin
         x = (h ^ {24'd0, b}) * FNV_PRIME;
      end else begin
         x = (h * FNV_PRIME) ^ {24'd0, b};
      end
      return x;
   endfunction

endpackage

### hw/rtl/fnv_hash_segment_distributor.sv
// Key bytes and undefined items are handled in the front in the cycle they are taken; null and
// no-key items hold the front for four bytes, one FNV multiply per byte through the mix step.
// A tuple's result passes through the hash queue, the 32-step remainder divider and the output
// register. The divider takes a new tuple only after it has loaded the last result, and a
// four-entry hash queue absorbs bursts.
// Reset is synchronous and active high: hash at the offset basis, counter zero, queue empty.
module fnv_hash_segment_distributor
   import fhsd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic [1:0]       req_action,
   input  logic [7:0]       req_data_byte,
   input  logic             req_first_of_tuple,
   input  logic             req_last_of_tuple,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [SEG_W-1:0] rsp_segment,
   output logic [31:0]      rsp_hash_value,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_wdata
);

   logic [CNT_W-1:0] segment_count_ff;
   logic             hash_variant_ff;
   rr_load_type      rr_load;
   q_wr_type         q_wr;
   q_rd_type         q_rd;
   logic             q_full;
   logic             q_pop;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         segment_count_ff <= CNT_W'(1);
         hash_variant_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SEGMENT_COUNT: segment_count_ff <= csr_wdata[CNT_W-1:0];
            CSR_HASH_VARIANT:  hash_variant_ff  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // A write of the round-robin start also loads the counter.
   assign rr_load.load  = csr_we & (csr_index_type'(csr_index) == CSR_ROUND_ROBIN_START);
   assign rr_load.value = csr_wdata;

   fhsd_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_action         (req_action),
      .req_data_byte      (req_data_byte),
      .req_first_of_tuple (req_first_of_tuple),
      .req_last_of_tuple  (req_last_of_tuple),
      .hash_variant       (hash_variant_ff),
      .rr_load            (rr_load),
      .q_full             (q_full),
      .q_wr               (q_wr)
   );

   fhsd_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_wr   (q_wr),
      .q_full (q_full),
      .q_pop  (q_pop),
      .q_rd   (q_rd)
   );

   fhsd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_rd           (q_rd),
      .q_pop          (q_pop),
      .segment_count  (segment_count_ff),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_segment    (rsp_segment),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule

### hw/rtl/fhsd_front.sv
module fhsd_front
   import fhsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_of_tuple,
   input  logic        req_last_of_tuple,
   input  logic        hash_variant,
   input  rr_load_type rr_load,
   input  logic        q_full,
   output q_wr_type    q_wr
);

   logic [31:0] hash_ff, hash_in;
   logic [31:0] rr_ff, rr_in;
   logic [31:0] word_ff, word_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        last_ff, last_in;
   logic        accept;
   logic [31:0] start;

   // A word item holds the front for four byte steps.
   assign req_full = busy_ff | q_full;
   assign accept   = req_push & ~req_full;
   assign start    = req_first_of_tuple ? FNV_BASIS : hash_ff;

   // Hash one byte per cycle unless stalled; a word item goes low byte first.
   always_comb begin
      hash_in    = hash_ff;
      rr_in      = rr_ff;
      word_in    = word_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      last_in    = last_ff;
      q_wr.push  = 1'b0;
      q_wr.hash  = hash_in;
      if (busy_ff) begin
         // The last byte step of a tuple end waits while the queue has no room.
         if (~(last_ff & q_full & (cnt_ff == 2'd3))) begin
            hash_in = fnv_mix(hash_ff, word_ff[8*cnt_ff +: 8], hash_variant);
            cnt_in  = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               busy_in   = 1'b0;
               q_wr.push = last_ff;
            end
         end
      end else if (accept) begin
         case (action_type'(req_action))
            ACT_KEY: begin
               hash_in   = fnv_mix(start, req_data_byte, hash_variant);
               q_wr.push = req_last_of_tuple;
            end
            ACT_NULL: begin
               hash_in = fnv_mix(start, NULL_WORD[7:0], hash_variant);
               word_in = NULL_WORD;
               cnt_in  = 2'd1;
               busy_in = 1'b1;
               last_in = req_last_of_tuple;
            end
            ACT_NOKEY: begin
               hash_in = fnv_mix(start, rr_ff[7:0], hash_variant);
               word_in = rr_ff;
               rr_in   = rr_ff + 32'd1;
               cnt_in  = 2'd1;
               busy_in = 1'b1;
               last_in = req_last_of_tuple;
            end
            default: begin
               // An undefined action hashes nothing but still marks the tuple.
               hash_in   = start;
               q_wr.push = req_last_of_tuple;
            end
         endcase
      end
      if (rr_load.load) begin
         rr_in = rr_load.value;
      end
      q_wr.hash = hash_in;
   end

   // Control and hash state.
   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= FNV_BASIS;
         rr_ff   <= 32'd0;
         busy_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         hash_ff <= hash_in;
         rr_ff   <= rr_in;
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Word and tuple-end mark of the item in progress.
   always_ff @(posedge clock) begin
      word_ff <= word_in;
      last_ff <= last_in;
   end

endmodule

### hw/rtl/fhsd_queue.sv
module fhsd_queue
   import fhsd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  q_wr_type q_wr,
   output logic     q_full,
   input  logic     q_pop,
   output q_rd_type q_rd
);

   logic [31:0]         mem [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign q_full   = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign do_push  = q_wr.push & ~q_full;
   assign do_pop   = q_pop & (count_ff != '0);
   assign q_rd.valid = (count_ff != '0);
   assign q_rd.hash  = mem[rd_ptr_ff];

   // Occupancy follows pushes and pops.
   always_comb begin
      count_in = count_ff;
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Pointers wrap at the power-of-two depth.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   // Storage write.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= q_wr.hash;
      end
   end

endmodule

### hw/rtl/fhsd_back.sv
module fhsd_back
   import fhsd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  q_rd_type         q_rd,
   output logic             q_pop,
   input  logic [CNT_W-1:0] segment_count,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [SEG_W-1:0] rsp_segment,
   output logic [31:0]      rsp_hash_value
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_DIV  = 3'b010,
      S_WAIT = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [31:0]        hash_ff;
   logic [31:0]        div_ff, div_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [REM_W-1:0]   n_ff, n_in;
   logic [DIV_CW-1:0]  step_ff, step_in;
   logic               out_valid_ff, out_valid_in;
   logic               out_load;
   logic [REM_W-1:0]   trial;

   assign rsp_empty = ~out_valid_ff;
   assign q_pop     = (state_ff == S_IDLE) & q_rd.valid;
   assign trial     = {rem_ff[REM_W-2:0], div_ff[31]};
   assign out_load  = (state_ff == S_WAIT) & (~out_valid_ff | rsp_pop);

   // Effective segment count: zero acts as one, large counts saturate.
   always_comb begin
      if (segment_count == '0) begin
         n_in = REM_W'(1);
      end else if (32'(segment_count) > 32'(MAX_SEGMENTS)) begin
         n_in = REM_W'(MAX_SEGMENTS);
      end else begin
         n_in = REM_W'(segment_count);
      end
   end

   // Restoring division, one quotient bit per cycle; only the remainder is kept.
   always_comb begin
      state_in = state_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_rd.valid) begin
               div_in   = q_rd.hash;
               rem_in   = '0;
               step_in  = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            div_in  = {div_ff[30:0], 1'b0};
            rem_in  = (trial >= n_ff) ? (trial - n_ff) : trial;
            step_in = step_ff + 1'b1;
            if (step_ff == DIV_CW'(DIV_STEPS - 1)) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The result register stays full until the transfer on the result side.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_pop & out_valid_ff) begin
         out_valid_in = 1'b0;
      end
      if (out_load) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         step_ff      <= step_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      div_ff <= div_in;
      rem_ff <= rem_in;
      if (q_pop) begin
         hash_ff <= q_rd.hash;
         n_ff    <= n_in;
      end
      if (out_load) begin
         rsp_segment    <= rem_ff[SEG_W-1:0];
         rsp_hash_value <= hash_ff;
      end
   end

endmodule
